// ===== design/bnu_pkg.sv =====
// bnu_pkg: shared types, constants and helpers for the backprop neuron unit
// holds the word structs, command/status codes, fsm states and the sigmoid rom
// no dependencies
package bnu_pkg;

  localparam int MAX_CONN   = 64;
  localparam int CONN_AW    = $clog2(MAX_CONN);
  localparam int CNT_W      = 7;
  localparam int LR_W       = 16;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 4;
  localparam int IDX_W      = 6;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int SIG_DEPTH  = 1024;
  localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);
  localparam int SIG_W      = 17;
  localparam int RANGE_HALF = 524288;
  localparam int RANGE_BITS = 20;
  localparam int Q_ONE      = 65536;
  localparam int LN2_Q16    = 45426;

  // accumulator wide enough for all floor-shifted products plus the bias
  localparam int ACC_W      = 48 + $clog2(MAX_CONN + 1);
  localparam int DIV_CNT_W  = $clog2(ACC_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 4'd0,
    CMD_SET_WEIGHT = 4'd1,
    CMD_READ_WEIGHT= 4'd2,
    CMD_SET_BIAS   = 4'd3,
    CMD_SET_DELTA  = 4'd4,
    CMD_SET_DBIAS  = 4'd5,
    CMD_SET_OUTPUT = 4'd6,
    CMD_STORE_IN   = 4'd7,
    CMD_FEED_FWD   = 4'd8,
    CMD_OUT_ERR    = 4'd9,
    CMD_HID_ERR    = 4'd10,
    CMD_ACCUM      = 4'd11,
    CMD_APPLY      = 4'd12
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_NO_CONN   = 2'd2,
    STAT_LR_ZERO   = 2'd3
  } stat_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONN_COUNT = 1'b0,
    CFG_LEARN_RATE = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RMW, S_WALK, S_DIV, S_LUT, S_LUT_WB,
    S_MUL1, S_MUL2, S_MUL3, S_GAIN, S_GAIN_WB, S_DONE
  } fsm_e;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] operand;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_data;
    logic signed [DATA_W-1:0] neuron_output;
    logic signed [DATA_W-1:0] error_term;
  } out_word_t;

  // one memory row per connection
  typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] delta;
    logic signed [DATA_W-1:0] inp;
  } row_t;

  typedef logic [SIG_W-1:0] sig_rom_t [SIG_DEPTH];

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] qadd(input logic signed [DATA_W-1:0] a,
                                                   input logic signed [DATA_W-1:0] b);
    return sat32(66'(a) + 66'(b));
  endfunction

  // floor shift of a q16 product, then saturate
  function automatic logic signed [DATA_W-1:0] qmul_sat(input logic signed [63:0] p);
    return sat32(66'(p >>> 16));
  endfunction

  // unsigned shift-subtract quotient, used only while building the rom
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid of table point k, q1.16, series form of exp(-|x|)
  function automatic logic [SIG_W-1:0] sig_entry(input int k);
    longint x;
    longint a;
    longint n;
    longint r;
    longint term;
    longint sum;
    longint unsigned e;
    longint unsigned den;
    longint unsigned s;
    x = longint'(udiv64(longint'(k) * 1048576, longint'(SIG_DEPTH))) - RANGE_HALF;
    a = (x < 0) ? -x : x;
    n = longint'(udiv64(a, longint'(LN2_Q16)));
    r = a - n * LN2_Q16;
    term = longint'(1) << 32;
    sum = term;
    for (int i = 1; i <= 12; i++) begin
      term = longint'(udiv64(term * r, longint'(i) << 16));
      if ((i & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    if (n > 40) n = 40;
    e = longint'(sum) >> n;
    den = (64'd1 << 32) + e;
    s = udiv64((64'd1 << 48) + (den >> 1), den);
    if (x < 0) return SIG_W'(longint'(Q_ONE) - longint'(s));
    else return SIG_W'(s);
  endfunction

  function automatic sig_rom_t build_sig_rom();
    sig_rom_t t;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      t[k] = sig_entry(k);
    end
    return t;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== design/backprop_neuron_unit_core.sv =====
// backprop_neuron_unit_core: one trainable sigmoid neuron with connection memory
// depends on bnu_pkg (types, codes, saturating helpers, sigmoid rom)
//
// usage
//   in_valid/in_ready carry one command word (cmd, index, operand); out_valid/
//   out_ready return one result word per command: status, read data, the
//   neuron output and the error term as they stand after the command.
//   cfg_we writes connection_count (index 0) or learning_rate (index 1) from
//   cfg_wdata; write it only while the block is idle.
// state sequence after decode, up to the raise of out_valid
//   set/clear/scalar: done; indexed: read-modify-write of one 96-bit row,
//   done; error: mul1, mul2, mul3, done; accumulate: gain, gain write-back,
//   walk, done; apply: walk, done; feed forward: walk, ACC_W=55 bit-serial
//   divide by count+1, lut, lut write-back, done. the walk moves one memory
//   row per cycle through a three-stage read / multiply / write-back pipeline.
// reset
//   synchronous, active low; row memory valid bits drop, so every row reads
//   as zero; bias/dbias/output/error clear; registers take 64 and 6554.
// stalls
//   a finished word sits in the output register; a new command is taken while
//   it waits, and the next result holds in S_DONE until out_ready frees it.
module backprop_neuron_unit_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bnu_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bnu_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [bnu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bnu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bnu_pkg::*;

  localparam logic signed [ACC_W:0] X_HALF = (ACC_W+1)'(RANGE_HALF);

  fsm_e state_r, state_nxt;

  // configuration registers
  logic [CNT_W-1:0] conn_count_r;
  logic [LR_W-1:0]  lr_r;

  // latched command word
  logic [CMD_W-1:0]         cmd_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [DATA_W-1:0] op_r;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_eff;
  stat_e            status_r;
  stat_e            dec_status;

  // scalar neuron state
  logic signed [DATA_W-1:0] rd_r;
  logic signed [DATA_W-1:0] bias_r;
  logic signed [DATA_W-1:0] dbias_r;
  logic signed [DATA_W-1:0] outv_r;
  logic signed [DATA_W-1:0] err_r;
  logic signed [DATA_W-1:0] gain_r;

  // row memory: weight, delta and input of one connection per row
  row_t               row_mem_r [MAX_CONN];
  row_t               mem_rdata_r;
  logic [MAX_CONN-1:0] row_vld_r;
  logic               rdata_vld_r;
  row_t               row_eff;
  logic [CONN_AW-1:0] mem_raddr;
  logic [CONN_AW-1:0] mem_waddr;
  logic               mem_we;
  row_t               mem_wdata;

  // shared multiplier
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic                     mul_en;
  logic signed [63:0]       mul_p;
  logic signed [63:0]       prod_r;
  logic signed [DATA_W-1:0] qmul_q;

  // connection walk pipeline
  logic [CNT_W-1:0]   issue_idx_r;
  logic               issue_act;
  logic               p1_vld_r;
  logic [CONN_AW-1:0] p1_addr_r;
  logic               p2_vld_r;
  logic [CONN_AW-1:0] p2_addr_r;
  row_t               p2_row_r;
  logic               walk_done;
  logic               walk_start;
  logic signed [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0]   acc_mag;

  // bit-serial divider by count+1
  logic [ACC_W-1:0]     dq_r;
  logic [CNT_W:0]       rem_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]       divisor;
  logic [CNT_W:0]       rem_sh;
  logic                 rem_ge;
  logic                 div_last;

  // sigmoid lookup
  logic signed [ACC_W:0]           x_q;
  logic [RANGE_BITS-1:0]           x_off;
  logic [RANGE_BITS+SIG_IDX_W-1:0] x_scaled;
  logic [SIG_IDX_W-1:0]            sig_idx;
  logic [SIG_W-1:0]                sig_rdata_r;

  logic      out_valid_r;
  out_word_t out_word_r;
  logic      out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || out_ready;

  assign row_eff = rdata_vld_r ? mem_rdata_r : '0;
  assign mul_p   = mul_a * mul_b;
  assign qmul_q  = qmul_sat(prod_r);

  assign cnt_eff   = (conn_count_r > CNT_W'(MAX_CONN)) ? CNT_W'(MAX_CONN) : conn_count_r;
  assign issue_act = (issue_idx_r < cnt_r);
  assign walk_done = (state_r == S_WALK) && !issue_act && !p1_vld_r && !p2_vld_r;
  assign walk_start = (state_nxt == S_WALK) && (state_r != S_WALK);
  assign acc_mag   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  assign divisor  = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign rem_sh   = {rem_r[CNT_W-1:0], dq_r[ACC_W-1]};
  assign rem_ge   = (rem_sh >= divisor);
  assign div_last = (div_cnt_r == DIV_CNT_W'(ACC_W - 1));

  // quotient back to signed, truncated toward zero
  assign x_q      = neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
  assign x_off    = x_q[RANGE_BITS-1:0] + RANGE_BITS'(RANGE_HALF);
  assign x_scaled = (RANGE_BITS+SIG_IDX_W)'(x_off) * (RANGE_BITS+SIG_IDX_W)'(SIG_DEPTH);

  always_comb begin
    if (x_q < -X_HALF) sig_idx = '0;
    else if (x_q >= X_HALF) sig_idx = SIG_IDX_W'(SIG_DEPTH - 1);
    else sig_idx = x_scaled[RANGE_BITS +: SIG_IDX_W];
  end

  // command checks against count and learning rate
  always_comb begin
    dec_status = STAT_OK;
    if (cmd_r inside {CMD_SET_WEIGHT, CMD_READ_WEIGHT, CMD_SET_DELTA, CMD_STORE_IN}) begin
      if (cnt_eff == '0) dec_status = STAT_NO_CONN;
      else if ({1'b0, idx_r} >= cnt_eff) dec_status = STAT_BAD_INDEX;
    end else if (cmd_r == CMD_FEED_FWD) begin
      if (cnt_eff == '0) dec_status = STAT_NO_CONN;
    end else if (cmd_r inside {CMD_ACCUM, CMD_APPLY}) begin
      if (cnt_eff == '0) dec_status = STAT_NO_CONN;
      else if (lr_r == '0) dec_status = STAT_LR_ZERO;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (dec_status != STAT_OK) begin
          state_nxt = S_DONE;
        end else begin
          case (cmd_r)
            CMD_SET_WEIGHT, CMD_READ_WEIGHT, CMD_SET_DELTA, CMD_STORE_IN: state_nxt = S_RMW;
            CMD_FEED_FWD, CMD_APPLY: state_nxt = S_WALK;
            CMD_ACCUM:               state_nxt = S_GAIN;
            CMD_OUT_ERR, CMD_HID_ERR: state_nxt = S_MUL1;
            default:                 state_nxt = S_DONE;
          endcase
        end
      end
      S_RMW:     state_nxt = S_DONE;
      S_WALK: begin
        if (walk_done) state_nxt = (cmd_r == CMD_FEED_FWD) ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_last) state_nxt = S_LUT;
      end
      S_LUT:     state_nxt = S_LUT_WB;
      S_LUT_WB:  state_nxt = S_DONE;
      S_MUL1:    state_nxt = S_MUL2;
      S_MUL2:    state_nxt = S_MUL3;
      S_MUL3:    state_nxt = S_DONE;
      S_GAIN:    state_nxt = S_GAIN_WB;
      S_GAIN_WB: state_nxt = S_WALK;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memory and multiplier control
  always_comb begin
    row_t wrow;
    wrow      = row_eff;
    mem_raddr = issue_idx_r[CONN_AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = p2_addr_r;
    mem_wdata = p2_row_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      S_DECODE: begin
        mem_raddr = CONN_AW'(idx_r);
      end
      S_RMW: begin
        mem_waddr = CONN_AW'(idx_r);
        case (cmd_r)
          CMD_SET_WEIGHT: wrow.weight = op_r;
          CMD_SET_DELTA:  wrow.delta  = op_r;
          CMD_STORE_IN:   wrow.inp    = op_r;
          default:        wrow        = row_eff;
        endcase
        mem_wdata = wrow;
        mem_we    = (cmd_r != CMD_READ_WEIGHT);
      end
      S_WALK: begin
        if (p1_vld_r) begin
          mul_en = 1'b1;
          mul_a  = (cmd_r == CMD_FEED_FWD) ? row_eff.inp : gain_r;
          mul_b  = (cmd_r == CMD_FEED_FWD) ? row_eff.weight : row_eff.inp;
        end
        if (p2_vld_r && cmd_r != CMD_FEED_FWD) begin
          wrow = p2_row_r;
          if (cmd_r == CMD_ACCUM) wrow.delta = qadd(p2_row_r.delta, qmul_q);
          else wrow.weight = qadd(p2_row_r.weight, p2_row_r.delta);
          mem_wdata = wrow;
          mem_we    = 1'b1;
        end
      end
      S_MUL1: begin
        mul_en = 1'b1;
        mul_a  = (cmd_r == CMD_OUT_ERR) ? sat32(66'(op_r) - 66'(outv_r)) : op_r;
        mul_b  = sat32(66'(Q_ONE) - 66'(outv_r));
      end
      S_MUL2: begin
        mul_en = 1'b1;
        mul_a  = qmul_q;
        mul_b  = outv_r;
      end
      S_GAIN: begin
        mul_en = 1'b1;
        mul_a  = $signed(DATA_W'(lr_r));
        mul_b  = err_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // row memory and sigmoid rom, registered reads
  always_ff @(posedge clk) begin
    if (mem_we) row_mem_r[mem_waddr] <= mem_wdata;
    mem_rdata_r <= row_mem_r[mem_raddr];
    sig_rdata_r <= SIG_ROM[sig_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      conn_count_r <= CNT_W'(64);
      lr_r         <= LR_W'(6554);
      row_vld_r    <= '0;
      rdata_vld_r  <= 1'b0;
      bias_r       <= '0;
      dbias_r      <= '0;
      outv_r       <= '0;
      err_r        <= '0;
      p1_vld_r     <= 1'b0;
      p2_vld_r     <= 1'b0;
      issue_idx_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_CONN_COUNT: conn_count_r <= cfg_wdata[CNT_W-1:0];
          CFG_LEARN_RATE: lr_r         <= cfg_wdata[LR_W-1:0];
          default:        lr_r         <= lr_r;
        endcase
      end

      if (in_valid && in_ready) begin
        cmd_r <= in_word.cmd;
        idx_r <= in_word.index;
        op_r  <= in_word.operand;
      end

      if (mem_we) row_vld_r[mem_waddr] <= 1'b1;
      rdata_vld_r <= row_vld_r[mem_raddr];

      if (mul_en) prod_r <= mul_p;

      case (state_r)
        S_DECODE: begin
          cnt_r    <= cnt_eff;
          status_r <= dec_status;
          rd_r     <= '0;
          if (dec_status == STAT_OK) begin
            case (cmd_r)
              CMD_CLEAR: begin
                row_vld_r <= '0;
                bias_r    <= '0;
                dbias_r   <= '0;
                outv_r    <= '0;
                err_r     <= '0;
              end
              CMD_SET_BIAS:   bias_r  <= op_r;
              CMD_SET_DBIAS:  dbias_r <= op_r;
              CMD_SET_OUTPUT: outv_r  <= op_r;
              default:        ;
            endcase
          end
        end
        S_RMW: begin
          if (cmd_r == CMD_READ_WEIGHT) rd_r <= row_eff.weight;
        end
        S_WALK: begin
          issue_idx_r <= issue_idx_r + CNT_W'(issue_act);
          p1_vld_r    <= issue_act;
          p1_addr_r   <= mem_raddr;
          p2_vld_r    <= p1_vld_r;
          p2_addr_r   <= p1_addr_r;
          p2_row_r    <= row_eff;
          if (p2_vld_r && cmd_r == CMD_FEED_FWD) acc_r <= acc_r + ACC_W'(prod_r >>> 16);
          if (walk_done) begin
            case (cmd_r)
              CMD_FEED_FWD: begin
                dq_r      <= acc_mag;
                neg_r     <= acc_r[ACC_W-1];
                rem_r     <= '0;
                div_cnt_r <= '0;
              end
              CMD_ACCUM: dbias_r <= qadd(dbias_r, gain_r);
              default:   bias_r  <= qadd(bias_r, dbias_r);
            endcase
          end
        end
        S_DIV: begin
          dq_r      <= {dq_r[ACC_W-2:0], rem_ge};
          rem_r     <= rem_ge ? (rem_sh - divisor) : rem_sh;
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
        end
        S_LUT_WB:  outv_r <= $signed({{(DATA_W-SIG_W){1'b0}}, sig_rdata_r});
        S_MUL3:    err_r  <= qmul_q;
        S_GAIN_WB: gain_r <= qmul_q;
        default:   ;
      endcase

      // walk entry overrides the pipeline registers
      if (walk_start) begin
        issue_idx_r <= '0;
        p1_vld_r    <= 1'b0;
        p2_vld_r    <= 1'b0;
        acc_r       <= ACC_W'(bias_r);
      end

      if (state_r == S_DONE && out_free) begin
        out_valid_r              <= 1'b1;
        out_word_r.status        <= status_r;
        out_word_r.read_data     <= rd_r;
        out_word_r.neuron_output <= outv_r;
        out_word_r.error_term    <= err_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // a write-back in the walk never hits the row being read
  a_walk_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && mem_we && issue_act) |-> (mem_waddr != mem_raddr))
    else $error("walk write-back collides with read row");

  // divider partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < divisor))
    else $error("divider remainder out of range");

  // pipeline stage two only follows stage one
  a_walk_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && p2_vld_r && !$past(walk_start)) |-> $past(p1_vld_r))
    else $error("walk stage two without stage one");

  // a result word is only produced from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result word loaded outside done state");

endmodule
